// ===== design/btok_pkg.sv =====
// shared types, constants and keyword tables for the byte stream tokenizer
package btok_pkg;

  // longest word length that is still counted, must fit the 7-bit length field
  localparam logic [6:0] MaxWord = 7'd64;

  // largest number value, numbers above it saturate
  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

  // token queue depth and pointer width
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // keyword ids
  localparam logic [1:0] KwExit  = 2'd0;
  localparam logic [1:0] KwFor   = 2'd1;
  localparam logic [1:0] KwWhile = 2'd2;

  // token kinds as seen on the output
  typedef enum logic [2:0] {
    KIND_SEMI  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_NUM   = 3'd3,
    KIND_KEY   = 3'd4,
    KIND_WORD  = 3'd5
  } kind_e;

  // one token with all of its fields
  typedef struct packed {
    kind_e       kind;
    logic [30:0] value;
    logic        ovf;
    logic [1:0]  kid;
    logic [6:0]  len;
  } token_t;

  // tokens caused by one byte: a full first token and an optional
  // single-character second token
  typedef struct packed {
    token_t first;
    logic   two;
    kind_e  second;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // length of keyword k
  function automatic logic [6:0] kw_len(input logic [1:0] k);
    logic [6:0] len;
    len = 7'd0;
    case (k)
      KwExit:  len = 7'd4;
      KwFor:   len = 7'd3;
      KwWhile: len = 7'd5;
      default: len = 7'd0;
    endcase
    return len;
  endfunction

  // true when letter c matches keyword k at position pos
  function automatic logic kw_hit(input logic [1:0] k, input logic [6:0] pos,
                                  input logic [7:0] c);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      KwExit: begin
        case (pos)
          7'd0:    ch = "e";
          7'd1:    ch = "x";
          7'd2:    ch = "i";
          7'd3:    ch = "t";
          default: ch = 8'h00;
        endcase
      end
      KwFor: begin
        case (pos)
          7'd0:    ch = "f";
          7'd1:    ch = "o";
          7'd2:    ch = "r";
          default: ch = 8'h00;
        endcase
      end
      KwWhile: begin
        case (pos)
          7'd0:    ch = "w";
          7'd1:    ch = "h";
          7'd2:    ch = "i";
          7'd3:    ch = "l";
          7'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return (ch != 8'h00) && (ch == c);
  endfunction

endpackage

// ===== design/btok_front.sv =====
// scanner front end: classifies each byte, tracks the pending run, builds token entries
module btok_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       src_byte_i,
  input  logic             end_mark_i,
  input  btok_pkg::qstat_t qstat_i,
  output logic             push_o,
  output btok_pkg::entry_t entry_o
);
  import btok_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [30:0] accum_q, accum_d;
  logic        ovf_q, ovf_d;
  logic [6:0]  count_q, count_d;
  logic [2:0]  cand_q, cand_d;

  logic        accept;
  logic        is_digit, is_letter, is_char;
  logic        in_num, in_word, cont_num, cont_word, brk;
  logic        run_valid, char_valid;
  token_t      run_tok, char_tok;
  kind_e       char_kind;

  logic [30:0] base_accum;
  logic        base_ovf;
  logic [34:0] prod;
  logic [30:0] accum_n;
  logic        ovf_n;
  logic [6:0]  base_count, count_n;
  logic [2:0]  base_cand, cand_n;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // byte classes
  always_comb begin
    is_digit  = src_byte_i inside {[8'h30:8'h39]};
    is_letter = (src_byte_i inside {[8'h41:8'h5A]}) || (src_byte_i inside {[8'h61:8'h7A]});
    is_char   = 1'b1;
    char_kind = KIND_SEMI;
    case (src_byte_i)
      ";":     char_kind = KIND_SEMI;
      "(":     char_kind = KIND_OPEN;
      ")":     char_kind = KIND_CLOSE;
      default: is_char   = 1'b0;
    endcase
  end

  // run continuation or break
  assign in_num    = (mode_q == MODE_NUM);
  assign in_word   = (mode_q == MODE_WORD);
  assign cont_num  = !end_mark_i && in_num && is_digit;
  assign cont_word = !end_mark_i && in_word && is_letter;
  assign brk       = !cont_num && !cont_word;

  // digit accumulate with saturation, starting from zero on a new run
  always_comb begin
    base_accum = cont_num ? accum_q : '0;
    base_ovf   = cont_num ? ovf_q : 1'b0;
    prod = {1'b0, base_accum, 3'b000} + {3'b000, base_accum, 1'b0}
         + {31'd0, src_byte_i[3:0]};
    if (prod > {4'd0, NumMax}) begin
      accum_n = NumMax;
      ovf_n   = 1'b1;
    end else begin
      accum_n = prod[30:0];
      ovf_n   = base_ovf;
    end
  end

  // letter count and keyword candidate update
  always_comb begin
    base_count = cont_word ? count_q : '0;
    base_cand  = cont_word ? cand_q : 3'b111;
    for (int k = 0; k < 3; k++) begin
      cand_n[k] = base_cand[k] && kw_hit(2'(k), base_count, src_byte_i);
    end
    count_n = (base_count < MaxWord) ? base_count + 7'd1 : base_count;
  end

  // token for the pending run
  always_comb begin
    run_tok       = '0;
    run_tok.kind  = KIND_NUM;
    if (in_num) begin
      run_tok.value = accum_q;
      run_tok.ovf   = ovf_q;
    end else begin
      run_tok.kind = KIND_WORD;
      run_tok.len  = count_q;
      for (int k = 0; k < 3; k++) begin
        if (cand_q[k] && (count_q == kw_len(2'(k)))) begin
          run_tok.kind = KIND_KEY;
          run_tok.kid  = 2'(k);
        end
      end
    end
    char_tok      = '0;
    char_tok.kind = char_kind;
  end

  assign run_valid  = brk && (in_num || in_word);
  assign char_valid = brk && !end_mark_i && is_char;

  // entry for the queue
  always_comb begin
    entry_o.first  = run_valid ? run_tok : char_tok;
    entry_o.two    = run_valid && char_valid;
    entry_o.second = char_kind;
    push_o         = accept && (run_valid || char_valid);
  end

  // next scan state
  always_comb begin
    mode_d  = mode_q;
    accum_d = accum_q;
    ovf_d   = ovf_q;
    count_d = count_q;
    cand_d  = cand_q;
    if (accept) begin
      if (cont_num) begin
        accum_d = accum_n;
        ovf_d   = ovf_n;
      end else if (cont_word) begin
        count_d = count_n;
        cand_d  = cand_n;
      end else begin
        mode_d  = MODE_IDLE;
        accum_d = '0;
        ovf_d   = 1'b0;
        count_d = '0;
        cand_d  = 3'b111;
        if (!end_mark_i && is_digit) begin
          mode_d  = MODE_NUM;
          accum_d = accum_n;
          ovf_d   = ovf_n;
        end else if (!end_mark_i && is_letter) begin
          mode_d  = MODE_WORD;
          count_d = count_n;
          cand_d  = cand_n;
        end
      end
    end
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      accum_q <= '0;
      ovf_q   <= 1'b0;
      count_q <= '0;
      cand_q  <= 3'b111;
    end else begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      ovf_q   <= ovf_d;
      count_q <= count_d;
      cand_q  <= cand_d;
    end
  end

endmodule

// ===== design/btok_queue.sv =====
// short queue of token entries between scanner and output side
module btok_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  btok_pkg::entry_t entry_i,
  input  logic             pop_i,
  output btok_pkg::entry_t entry_o,
  output btok_pkg::qstat_t qstat_o
);
  import btok_pkg::*;

  entry_t            slot_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign entry_o = slot_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== design/btok_back.sv =====
// output side: splits entries into single tokens and holds the output register
module btok_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  btok_pkg::entry_t entry_i,
  input  btok_pkg::qstat_t qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output btok_pkg::token_t tok_o,
  output logic             last_o
);
  import btok_pkg::*;

  logic   out_valid_q, out_valid_d;
  logic   phase_q, phase_d;
  token_t tok_q, tok_d;
  logic   last_q, last_d;
  logic   load;

  // load a token whenever the output register is free or being taken and the queue is not empty
  assign load  = (!out_valid_q || out_ready_i) && !qstat_i.empty;
  assign pop_o = load && (phase_q || !entry_i.two);

  // pick the first or second token of the head entry
  always_comb begin
    tok_d       = tok_q;
    last_d      = last_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (phase_q) begin
        tok_d      = '0;
        tok_d.kind = entry_i.second;
        last_d     = 1'b1;
        phase_d    = 1'b0;
      end else begin
        tok_d   = entry_i.first;
        last_d  = !entry_i.two;
        phase_d = entry_i.two;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign tok_o       = tok_q;
  assign last_o      = last_q;

endmodule

// ===== design/byte_stream_tokenizer.sv =====
// top level of the byte stream tokenizer
// Takes one source byte per request (or an end marker) and returns tokens: semicolon,
// open and close paren, saturating decimal number, keyword (exit, for, while) and word
// with its saturated length. A byte is accepted in the cycle it is offered as long as
// the four-entry token queue has room, so the input runs at one byte per cycle; the
// output register hands out one token per cycle while out_ready is high, so a byte that
// ends a run and also emits a punctuation token yields two tokens, and a stream rich in
// those fills the queue and holds back the input. Tokens pass through a queue slot, then
// the output register; those of a number or word appear when the run ends, on the byte
// that ends it or on the end marker. last_of_run marks the final token of a byte.
module byte_stream_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  src_byte_i,
  input  logic        end_mark_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [30:0] number_value_o,
  output logic        number_overflow_o,
  output logic [1:0]  keyword_id_o,
  output logic [6:0]  word_length_o,
  output logic        last_of_run_o
);
  import btok_pkg::*;

  logic   push, pop;
  entry_t push_entry, head_entry;
  qstat_t qstat;
  token_t tok;

  // scanner
  btok_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .src_byte_i (src_byte_i),
    .end_mark_i (end_mark_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // token queue
  btok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  // output side
  btok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o      = tok.kind;
  assign number_value_o    = tok.value;
  assign number_overflow_o = tok.ovf;
  assign keyword_id_o      = tok.kid;
  assign word_length_o     = tok.len;

  // queue can never be full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("token queue full and empty together");

  // second token of a byte follows right after the first is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("second token of a byte not presented back to back");

  // only number tokens carry a value or overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != 3'(KIND_NUM)) |->
      (number_value_o == '0) && !number_overflow_o)
    else $error("value on a non-number token");

  // keyword id only on keyword tokens, kind always in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (token_kind_o <= 3'(KIND_WORD)) &&
      ((token_kind_o == 3'(KIND_KEY)) || (keyword_id_o == KwExit)))
    else $error("bad token kind or keyword id");

endmodule
